// File: hdl/mspf_pkg.sv
// Shared types, constants and helpers for the matrix saddle point finder.
// No dependencies; imported by every module of the block.
package mspf_pkg;

    localparam int MAX_ROWS_DEF    = 16;
    localparam int MAX_COLUMNS_DEF = 16;

    localparam int VAL_W  = 32;   // element / result value width
    localparam int IDX_W  = 4;    // row_index / column_index width
    localparam int CFG_W  = 5;    // configuration register width
    localparam int CFG_AW = 1;    // configuration index width

    localparam logic [CFG_AW-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_COLUMN_COUNT = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic load_we;     // store one element
        logic row_init;    // start the scan at row 0
        logic row_read;    // issue one row element read
        logic col_read;    // issue one column element read
        logic row_next;    // advance to the next row
        logic commit;      // current row is a saddle: park it as pending
        logic emit_pend;   // send pending result, not last
        logic emit_final;  // send pending (last) or the not-found result
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic load_last;   // the element on the input completes the matrix
        logic col_last;    // row read at the last column
        logic k_last;      // column read at the last row
        logic row_last;    // scanning the last row
        logic ok;          // row max is its column minimum
        logic pend_vld;    // a saddle result is parked
        logic out_free;    // output register can take a result
    } t_dp_stat;

    // 0 reads as 1, anything above the maximum reads as the maximum
    function automatic logic [6:0] f_clamp(input logic [CFG_W-1:0] v,
                                           input int unsigned maxv);
        logic [6:0] res;
        if (v == '0) begin
            res = 7'd1;
        end else if (v > maxv) begin
            res = maxv[6:0];
        end else begin
            res = {2'b00, v};
        end
        return res;
    endfunction

endpackage

// File: hdl/mspf_datapath.sv
// Datapath: element store, load position, scan counters, max/min compare,
// pending saddle result and output register. Depends on mspf_pkg.
module mspf_datapath #(
    parameter int MAX_ROWS    = mspf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = mspf_pkg::MAX_COLUMNS_DEF,
    localparam int DEPTH = MAX_ROWS * MAX_COLUMNS,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int LPW   = $clog2(DEPTH + 1),
    localparam int RCW   = $clog2(MAX_ROWS + 1),
    localparam int CCW   = $clog2(MAX_COLUMNS + 1),
    localparam int RIW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    localparam int CIW   = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic signed [mspf_pkg::VAL_W-1:0]      i_element_value,
    input  logic [RCW-1:0]                         i_rows,
    input  logic [CCW-1:0]                         i_cols,
    input  mspf_pkg::t_dp_cmd                      i_cmd,
    output mspf_pkg::t_dp_stat                     o_stat,
    input  logic                                   i_stall,
    output logic                                   o_valid,
    output logic                                   o_found,
    output logic [mspf_pkg::IDX_W-1:0]             o_row_index,
    output logic [mspf_pkg::IDX_W-1:0]             o_column_index,
    output logic signed [mspf_pkg::VAL_W-1:0]      o_saddle_value,
    output logic                                   o_last_result
);
    import mspf_pkg::*;

    logic [VAL_W-1:0]        r_mem [DEPTH];
    logic [VAL_W-1:0]        r_mem_q;
    logic [LPW-1:0]          r_pos;
    logic [LPW-1:0]          total;
    logic [LPW-1:0]          pos_inc;

    logic [CIW-1:0]          r_c;
    logic [RIW-1:0]          r_k;
    logic [RIW-1:0]          r_r;
    logic [AW-1:0]           r_base;
    logic [AW-1:0]           r_col_addr;
    logic [AW-1:0]           addr_row;
    logic [AW-1:0]           addr_col;
    logic [AW-1:0]           rd_addr;

    logic                    r_rdv_row;
    logic                    r_rdv_col;
    logic                    r_rd_first;
    logic [CIW-1:0]          r_rd_cidx;

    logic signed [VAL_W-1:0] r_best;
    logic [CIW-1:0]          r_bcol;
    logic                    r_ok;

    logic                    r_pend_vld;
    logic [IDX_W-1:0]        r_pend_row;
    logic [IDX_W-1:0]        r_pend_col;
    logic signed [VAL_W-1:0] r_pend_val;

    logic                    r_o_valid;
    logic                    out_free;
    logic [RIW+IDX_W-1:0]    row_ext;
    logic [CIW+IDX_W-1:0]    col_ext;

    assign total   = LPW'(LPW'(i_rows) * LPW'(i_cols));
    assign pos_inc = r_pos + 1'b1;

    assign addr_row = r_base + AW'(r_c);
    assign addr_col = (r_k == '0) ? AW'(r_bcol) : r_col_addr;
    assign rd_addr  = i_cmd.row_read ? addr_row : addr_col;

    assign out_free = !r_o_valid || !i_stall;

    // row and column indexes masked to the 4-bit result fields
    assign row_ext = (RIW + IDX_W)'(r_r);
    assign col_ext = (CIW + IDX_W)'(r_bcol);

    always_comb begin
        o_stat           = '0;
        o_stat.load_last = (pos_inc >= total);
        o_stat.col_last  = (CCW'(r_c) == i_cols - 1'b1);
        o_stat.k_last    = (RCW'(r_k) == i_rows - 1'b1);
        o_stat.row_last  = (RCW'(r_r) == i_rows - 1'b1);
        o_stat.ok        = r_ok;
        o_stat.pend_vld  = r_pend_vld;
        o_stat.out_free  = out_free;
    end

    // element store: one write port for loading, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            r_mem[r_pos[AW-1:0]] <= i_element_value;
        end
        if (i_cmd.row_read || i_cmd.col_read) begin
            r_mem_q <= r_mem[rd_addr];
        end
    end

    // load position and scan counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_rdv_row <= 1'b0;
            r_rdv_col <= 1'b0;
        end else begin
            if (i_cmd.load_we) begin
                r_pos <= o_stat.load_last ? '0 : pos_inc;
            end
            r_rdv_row <= i_cmd.row_read;
            r_rdv_col <= i_cmd.col_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_init) begin
            r_r    <= '0;
            r_base <= '0;
            r_c    <= '0;
            r_k    <= '0;
        end else if (i_cmd.row_next) begin
            r_r    <= r_r + 1'b1;
            r_base <= r_base + AW'(i_cols);
        end
        if (i_cmd.row_read) begin
            r_c <= o_stat.col_last ? '0 : r_c + 1'b1;
        end
        if (i_cmd.col_read) begin
            r_k        <= o_stat.k_last ? '0 : r_k + 1'b1;
            r_col_addr <= addr_col + AW'(i_cols);
        end
        r_rd_first <= (r_c == '0);
        r_rd_cidx  <= r_c;
    end

    // row maximum (later column wins a tie), then column minimum check
    always_ff @(posedge i_clk) begin
        if (r_rdv_row) begin
            if (r_rd_first || ($signed(r_mem_q) >= r_best)) begin
                r_best <= $signed(r_mem_q);
                r_bcol <= r_rd_cidx;
            end
        end
        if (i_cmd.row_init || i_cmd.row_next) begin
            r_ok <= 1'b1;
        end else if (r_rdv_col && ($signed(r_mem_q) < r_best)) begin
            r_ok <= 1'b0;
        end
    end

    // pending result and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_vld <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (i_cmd.emit_final) begin
                r_pend_vld <= 1'b0;
            end else if (i_cmd.commit) begin
                r_pend_vld <= 1'b1;
            end
            if (i_cmd.emit_pend || i_cmd.emit_final) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_pend_row <= row_ext[IDX_W-1:0];
            r_pend_col <= col_ext[IDX_W-1:0];
            r_pend_val <= r_best;
        end
        if (i_cmd.emit_pend || (i_cmd.emit_final && r_pend_vld)) begin
            o_found        <= 1'b1;
            o_row_index    <= r_pend_row;
            o_column_index <= r_pend_col;
            o_saddle_value <= r_pend_val;
            o_last_result  <= i_cmd.emit_final;
        end else if (i_cmd.emit_final) begin
            o_found        <= 1'b0;
            o_row_index    <= '0;
            o_column_index <= '0;
            o_saddle_value <= '0;
            o_last_result  <= 1'b1;
        end
    end

    assign o_valid = r_o_valid;

endmodule

// File: hdl/mspf_ctrl.sv
// Controller: sequences loading, row scans, column checks and result hand-off.
// Depends on mspf_pkg; drives mspf_datapath through t_dp_cmd.
module mspf_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  mspf_pkg::t_dp_stat  i_stat,
    output mspf_pkg::t_dp_cmd   o_cmd
);
    import mspf_pkg::*;

    typedef enum logic [2:0] {
        S_LOAD,
        S_ROW,
        S_ROW_WAIT,
        S_COL,
        S_COL_WAIT,
        S_ROW_END,
        S_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   n_stall;
    logic   accept;

    assign accept = i_valid && !r_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (accept) begin
                    o_cmd.load_we = 1'b1;
                    if (i_stat.load_last) begin
                        o_cmd.row_init = 1'b1;
                        n_state        = S_ROW;
                    end
                end
            end
            S_ROW: begin
                o_cmd.row_read = 1'b1;
                if (i_stat.col_last) begin
                    n_state = S_ROW_WAIT;
                end
            end
            S_ROW_WAIT: begin
                n_state = S_COL;
            end
            S_COL: begin
                o_cmd.col_read = 1'b1;
                if (i_stat.k_last) begin
                    n_state = S_COL_WAIT;
                end
            end
            S_COL_WAIT: begin
                n_state = S_ROW_END;
            end
            S_ROW_END: begin
                if (!(i_stat.ok && i_stat.pend_vld && !i_stat.out_free)) begin
                    if (i_stat.ok) begin
                        o_cmd.commit    = 1'b1;
                        o_cmd.emit_pend = i_stat.pend_vld;
                    end
                    if (i_stat.row_last) begin
                        n_state = S_FINISH;
                    end else begin
                        o_cmd.row_next = 1'b1;
                        n_state        = S_ROW;
                    end
                end
            end
            S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
        n_stall = (n_state != S_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_stall <= 1'b0;
        end else begin
            r_state <= n_state;
            r_stall <= n_stall;
        end
    end

    assign o_stall = r_stall;

endmodule

// File: hdl/matrix_saddle_point_finder_core.sv
// Top level of the matrix saddle point finder: configuration registers,
// size clamping, controller and datapath. Depends on mspf_pkg, mspf_ctrl,
// mspf_datapath.
//
// Usage:
// - Set row_count (index 0) and column_count (index 1) through the write
//   port while the block is idle. 0 reads as 1, values above the maximum
//   read as the maximum. Both reset to 1.
// - Input channel (i_valid / o_stall): one element per transfer, row-major.
//   While loading, one element is taken every cycle.
// - After the element that completes the matrix, o_stall rises and the
//   block scans row by row from its element store, one read per cycle:
//   cols reads for the row maximum, a compare step, rows reads down
//   that column, a compare step and a decision step.
// - Output channel (o_valid / i_stall): one transfer per saddle row, or a
//   single not-found transfer; the final one has o_last_result set. Results
//   are held one deep, so the last marker is known when a result leaves.
// - A stalled receiver freezes the scan at the next saddle row until the
//   output register frees up; nothing is lost.
// - Reset (synchronous, active low) clears the load position, the
//   scan state and the output valid; the element store is not cleared.
module matrix_saddle_point_finder_core #(
    parameter int MAX_ROWS    = mspf_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLUMNS = mspf_pkg::MAX_COLUMNS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_wr_en,
    input  logic [mspf_pkg::CFG_AW-1:0]        i_cfg_addr,
    input  logic [mspf_pkg::CFG_W-1:0]         i_cfg_wdata,
    // element input channel
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [mspf_pkg::VAL_W-1:0]  i_element_value,
    // result output channel
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic                               o_found,
    output logic [mspf_pkg::IDX_W-1:0]         o_row_index,
    output logic [mspf_pkg::IDX_W-1:0]         o_column_index,
    output logic signed [mspf_pkg::VAL_W-1:0]  o_saddle_value,
    output logic                               o_last_result
);
    import mspf_pkg::*;

    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int CCW = $clog2(MAX_COLUMNS + 1);

    logic [CFG_W-1:0] r_row_count;
    logic [CFG_W-1:0] r_column_count;
    logic [RCW-1:0]   rows;
    logic [CCW-1:0]   cols;
    t_dp_cmd          cmd;
    t_dp_stat         stat;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= CFG_W'(1);
            r_column_count <= CFG_W'(1);
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                CFG_ROW_COUNT:    r_row_count    <= i_cfg_wdata;
                CFG_COLUMN_COUNT: r_column_count <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // sizes in use, clamped to 1..maximum
    assign rows = RCW'(f_clamp(r_row_count, MAX_ROWS));
    assign cols = CCW'(f_clamp(r_column_count, MAX_COLUMNS));

    mspf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mspf_datapath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_element_value (i_element_value),
        .i_rows          (rows),
        .i_cols          (cols),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_stall         (i_stall),
        .o_valid         (o_valid),
        .o_found         (o_found),
        .o_row_index     (o_row_index),
        .o_column_index  (o_column_index),
        .o_saddle_value  (o_saddle_value),
        .o_last_result   (o_last_result)
    );

endmodule
